FILE: src/assert_macros.svh
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent required in the cycle after the antecedent, outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/b64d_pkg.sv
// types and constants of the base64 stream decoder
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned CODE_BITS = 6;

    localparam logic [7:0] PAD_CHAR   = 8'h3D; // '='
    localparam logic [7:0] PLUS_CHAR  = 8'h2B; // '+'
    localparam logic [7:0] SLASH_CHAR = 8'h2F; // '/'
    localparam logic [7:0] UPPER_A    = 8'h41; // 'A'
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] LOWER_A    = 8'h61; // 'a'
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] DIGIT_0    = 8'h30; // '0'
    localparam logic [7:0] DIGIT_9    = 8'h39;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_INVALID = 2'd1,
        ERR_PAD     = 2'd2,
        ERR_MISSING = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic [1:0] error_code;
        logic       message_end;
    } t_out_item;

    typedef struct packed {
        logic       is_pad;
        logic       is_code;
        logic [5:0] code;
    } t_char_info;

endpackage

`default_nettype wire

FILE: src/b64d_char_map.sv
// maps one ascii character to its 6-bit base64 code
`timescale 1ns / 1ps
`default_nettype none

module b64d_char_map (
    input  wire logic [7:0]            i_character,
    output b64d_pkg::t_char_info       o_info
);

    logic [7:0] w_diff;

    always_comb begin
        w_diff         = 8'd0;
        o_info.is_pad  = (i_character == b64d_pkg::PAD_CHAR);
        o_info.is_code = 1'b1;
        o_info.code    = 6'd0;
        if (i_character >= b64d_pkg::UPPER_A && i_character <= b64d_pkg::UPPER_Z) begin
            w_diff      = i_character - b64d_pkg::UPPER_A;
            o_info.code = w_diff[5:0];
        end else if (i_character >= b64d_pkg::LOWER_A && i_character <= b64d_pkg::LOWER_Z) begin
            w_diff      = i_character - b64d_pkg::LOWER_A + 8'd26;
            o_info.code = w_diff[5:0];
        end else if (i_character >= b64d_pkg::DIGIT_0 && i_character <= b64d_pkg::DIGIT_9) begin
            w_diff      = i_character - b64d_pkg::DIGIT_0 + 8'd52;
            o_info.code = w_diff[5:0];
        end else if (i_character == b64d_pkg::PLUS_CHAR) begin
            o_info.code = 6'd62;
        end else if (i_character == b64d_pkg::SLASH_CHAR) begin
            o_info.code = 6'd63;
        end else begin
            o_info.is_code = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: src/b64d_unpack.sv
// bit packing state and per-item result of the decoder
`timescale 1ns / 1ps
`default_nettype none

module b64d_unpack (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire b64d_pkg::t_in_item    i_item,
    output b64d_pkg::t_out_item        o_result
);

    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_partial, n_partial;
    logic             r_pad_mode, n_pad_mode;
    b64d_pkg::t_err   r_err, n_err;

    b64d_pkg::t_char_info w_info;
    logic [3:0]  w_sum;
    logic [7:0]  w_acc;
    logic [13:0] w_wide;
    logic        w_valid;
    logic [7:0]  w_byte;

    b64d_char_map u_char_map (
        .i_character (i_item.character),
        .o_info      (w_info)
    );

    always_comb begin
        n_phase    = r_phase;
        n_partial  = r_partial;
        n_pad_mode = r_pad_mode;
        n_err      = r_err;
        w_valid    = 1'b0;
        w_byte     = 8'd0;
        w_sum      = {1'b0, r_phase} + 4'(b64d_pkg::CODE_BITS);
        w_acc      = r_partial;
        w_wide     = 14'd0;
        if (r_err == b64d_pkg::ERR_NONE) begin
            if (w_info.is_pad) begin
                if (r_phase == 3'd0) begin
                    n_err = b64d_pkg::ERR_PAD;
                end else begin
                    n_phase    = w_sum[2:0];
                    n_partial  = 8'd0;
                    n_pad_mode = (w_sum[2:0] != 3'd0);
                end
            end else if (r_pad_mode) begin
                n_err = b64d_pkg::ERR_MISSING;
            end else if (!w_info.is_code) begin
                n_err = b64d_pkg::ERR_INVALID;
            end else begin
                // merge the code into the byte under construction
                if (r_phase == 3'd0) begin
                    w_acc = r_partial | {w_info.code, 2'b00};
                end else begin
                    w_acc = r_partial | {2'b00, w_info.code >> (r_phase - 3'd2)};
                end
                if (w_sum[3]) begin
                    w_valid = 1'b1;
                    w_byte  = w_acc;
                    w_wide  = {8'd0, w_info.code} << (4'd8 - {1'b0, w_sum[2:0]});
                    n_partial = (w_sum[2:0] == 3'd0) ? 8'd0 : w_wide[7:0];
                end else begin
                    n_partial = w_acc;
                end
                n_phase = w_sum[2:0];
            end
            if (i_item.last_char && n_err == b64d_pkg::ERR_NONE && n_pad_mode) begin
                n_err = b64d_pkg::ERR_MISSING;
            end
        end
        o_result.data_byte   = w_byte;
        o_result.byte_valid  = w_valid;
        o_result.error_code  = n_err;
        o_result.message_end = i_item.last_char;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= 3'd0;
            r_partial  <= 8'd0;
            r_pad_mode <= 1'b0;
            r_err      <= b64d_pkg::ERR_NONE;
        end else if (i_step) begin
            if (i_item.last_char) begin
                r_phase    <= 3'd0;
                r_partial  <= 8'd0;
                r_pad_mode <= 1'b0;
                r_err      <= b64d_pkg::ERR_NONE;
            end else begin
                r_phase    <= n_phase;
                r_partial  <= n_partial;
                r_pad_mode <= n_pad_mode;
                r_err      <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/base64_stream_decoder_top.sv
// top level of the streaming base64 decoder
// usage
//   input channel: one base64 character per item in i_in_data, with
//   last_char marking the final character of a message
//   output channel: exactly one result item per input item, in order:
//   a decoded byte with byte_valid, the held error code and message_end
//   timing
//   an accepted item sits in the input register, its result is computed
//   from there and lands in the output register, raising o_out_valid,
//   when that register has room; one item per cycle sustained while
//   i_out_ready is high; the only loop is the decode state (bit phase,
//   partial byte, pad mode, error) updated once per item
//   stalls
//   when the receiver holds i_out_ready low the output register keeps its
//   item and the input register can still take one more item; only when
//   both are full does o_in_ready drop
//   reset
//   synchronous active-low reset empties both registers and returns the
//   decode state to phase zero, no pad run and no error
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module base64_stream_decoder_top (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire b64d_pkg::t_in_item    i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output b64d_pkg::t_out_item        o_out_data
);

    // input register
    logic                 r_in_valid;
    b64d_pkg::t_in_item   r_in;

    // output register
    logic                 r_out_valid;
    b64d_pkg::t_out_item  r_out;

    b64d_pkg::t_out_item  w_result;
    logic                 w_advance;

    // item moves from input register to output register when there is room
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    b64d_unpack u_unpack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_in),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // input side
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            // output side
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a stalled result must not be overwritten
    `ASSERT_CLK(a_no_overwrite, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |-> !w_advance, "result overwritten while stalled")
    // a byte is never given out while an error is reported
    `ASSERT_CLK(a_byte_no_error, i_clk, i_rst_n, (o_out_valid && o_out_data.byte_valid) |-> (o_out_data.error_code == b64d_pkg::ERR_NONE), "byte given out with error")
    // every advanced item produces a valid result next cycle
    `ASSERT_NEXT(a_advance_out, i_clk, i_rst_n, w_advance, r_out_valid, "advanced item lost")

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// self-checking testbench of the streaming base64 decoder
`timescale 1ns / 1ps

module tb_top;

    // sender and receiver stop idling once this few characters are left to send
    localparam int CALM_TAIL    = 200;
    // characters of random messages to generate after the directed part
    localparam int RANDOM_CHARS = 1300;
    // receiver hold-off that backs the block up
    localparam int BACKLOG_AT   = 400;
    localparam int BACKLOG_LEN  = 60;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    b64d_pkg::t_in_item   i_in_data   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    b64d_pkg::t_out_item  o_out_data;

    // characters waiting to be offered and outputs predicted for accepted ones
    b64d_pkg::t_in_item   pending_chars[$];
    b64d_pkg::t_out_item  predicted_outs[$];
    // message being assembled before it joins pending_chars
    b64d_pkg::t_in_item   msg_buf[$];

    // decode state of the predictor
    logic [2:0]     dec_phase   = '0;
    logic [7:0]     dec_partial = '0;
    logic           dec_in_pad  = 1'b0;
    b64d_pkg::t_err dec_err     = b64d_pkg::ERR_NONE;

    int         chars_sent   = 0;
    int         fail_count   = 0;
    int         send_gap     = 0;
    int         stall_left   = 0;
    int         backlog_hold = 0;
    logic       backlog_done = 1'b0;

    base64_stream_decoder_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // one character through the predictor: updates the decode state and
    // returns the output item it must produce
    function automatic b64d_pkg::t_out_item decode_char(b64d_pkg::t_in_item it);
        b64d_pkg::t_out_item res;
        logic [7:0] c;
        logic [5:0] sextet;
        logic       is_code;
        logic [3:0] fill;
        logic [7:0] acc;
        res = '0;
        c = it.character;
        if (dec_err == b64d_pkg::ERR_NONE) begin
            if (c == b64d_pkg::PAD_CHAR) begin
                // pad only legal while a byte is partly filled
                if (dec_phase == 3'd0) begin
                    dec_err = b64d_pkg::ERR_PAD;
                end else begin
                    dec_phase   = dec_phase + 3'd6;
                    dec_partial = '0;
                    dec_in_pad  = (dec_phase != 3'd0);
                end
            end else if (dec_in_pad) begin
                // data before the pad run reached a byte boundary
                dec_err = b64d_pkg::ERR_MISSING;
            end else begin
                is_code = 1'b1;
                sextet  = '0;
                if (c >= b64d_pkg::UPPER_A && c <= b64d_pkg::UPPER_Z) begin
                    sextet = 6'(c - b64d_pkg::UPPER_A);
                end else if (c >= b64d_pkg::LOWER_A && c <= b64d_pkg::LOWER_Z) begin
                    sextet = 6'(c - b64d_pkg::LOWER_A + 8'd26);
                end else if (c >= b64d_pkg::DIGIT_0 && c <= b64d_pkg::DIGIT_9) begin
                    sextet = 6'(c - b64d_pkg::DIGIT_0 + 8'd52);
                end else if (c == b64d_pkg::PLUS_CHAR) begin
                    sextet = 6'd62;
                end else if (c == b64d_pkg::SLASH_CHAR) begin
                    sextet = 6'd63;
                end else begin
                    is_code = 1'b0;
                end
                if (!is_code) begin
                    dec_err = b64d_pkg::ERR_INVALID;
                end else begin
                    // msb-first packing of the six new bits
                    acc  = dec_partial | ({sextet, 2'b00} >> dec_phase);
                    fill = dec_phase + 4'd6;
                    if (fill >= 4'd8) begin
                        res.byte_valid = 1'b1;
                        res.data_byte  = acc;
                        fill = fill - 4'd8;
                        acc  = (fill == 4'd0) ? 8'd0 : ({2'b00, sextet} << (8 - fill));
                    end
                    dec_phase   = fill[2:0];
                    dec_partial = acc;
                end
            end
            // message may not end inside a pad run
            if (it.last_char && dec_err == b64d_pkg::ERR_NONE && dec_in_pad)
                dec_err = b64d_pkg::ERR_MISSING;
        end
        res.error_code  = dec_err;
        res.message_end = it.last_char;
        if (it.last_char) begin
            dec_phase   = '0;
            dec_partial = '0;
            dec_in_pad  = 1'b0;
            dec_err     = b64d_pkg::ERR_NONE;
        end
        return res;
    endfunction

    function automatic b64d_pkg::t_in_item mk_char(logic [7:0] c, logic last);
        b64d_pkg::t_in_item it;
        it.character = c;
        it.last_char = last;
        return it;
    endfunction

    // append one character to the message being assembled
    function automatic void stash_char(b64d_pkg::t_in_item it);
        msg_buf.insert(msg_buf.size(), it);
    endfunction

    function automatic logic [7:0] b64_char(logic [5:0] v);
        if (v < 6'd26) return b64d_pkg::UPPER_A + v;
        if (v < 6'd52) return b64d_pkg::LOWER_A + (v - 6'd26);
        if (v < 6'd62) return b64d_pkg::DIGIT_0 + (v - 6'd52);
        if (v == 6'd62) return b64d_pkg::PLUS_CHAR;
        return b64d_pkg::SLASH_CHAR;
    endfunction

    // base64 text of n random bytes into msg_buf, with or without padding
    task automatic encode_group(input int n_bytes, input bit pad_tail);
        int         acc;
        int         nbits;
        logic [5:0] v;
        acc   = 0;
        nbits = 0;
        for (int i = 0; i < n_bytes; i++) begin
            acc   = ((acc << 8) | $urandom_range(0, 255)) & 32'hFFFF;
            nbits = nbits + 8;
            while (nbits >= 6) begin
                v = 6'((acc >> (nbits - 6)) & 63);
                stash_char(mk_char(b64_char(v), 1'b0));
                nbits = nbits - 6;
            end
        end
        if (nbits != 0) begin
            // leftover bits on top, random filler below since it is dropped
            v = 6'(((acc << (6 - nbits)) | $urandom_range(0, (1 << (6 - nbits)) - 1)) & 63);
            stash_char(mk_char(b64_char(v), 1'b0));
            if (pad_tail)
                repeat ((6 - nbits) / 2) stash_char(mk_char(b64d_pkg::PAD_CHAR, 1'b0));
        end
    endtask

    // flag the last character and queue the whole message for sending
    task automatic queue_message(input string text);
        for (int i = 0; i < text.len(); i++)
            stash_char(mk_char(text[i], 1'b0));
        if (msg_buf.size() != 0)
            msg_buf[msg_buf.size() - 1].last_char = 1'b1;
        pending_chars = {pending_chars, msg_buf};
        msg_buf.delete();
    endtask

    // stimulus: directed messages first, then random ones
    initial begin
        int random_count;
        int kind;
        int groups;
        int pos;
        random_count = 0;

        // padded two-byte group
        queue_message("TWE=");
        // message ends inside a pad run
        queue_message("TQ=");
        // pad at a byte boundary
        queue_message("=");
        // extra pad after the run reached the boundary
        queue_message("TQ===");
        // data character inside a pad run
        queue_message("TQ=A");
        // invalid characters at both ends of the byte range
        stash_char(mk_char(8'hFF, 1'b0));
        stash_char(mk_char(8'h00, 1'b0));
        queue_message("");
        // alphabet extremes, then an unpadded tail whose leftover bits are dropped
        queue_message("+/09Az");

        while (random_count < RANDOM_CHARS) begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                // noise: any byte values
                repeat ($urandom_range(1, 5))
                    stash_char(mk_char(8'($urandom_range(0, 255)), 1'b0));
            end else begin
                // well-formed: padded groups one after another, tail may be unpadded
                groups = $urandom_range(1, 3);
                for (int g = 0; g < groups; g++)
                    encode_group($urandom_range(1, 7), (g != groups - 1) || $urandom_range(0, 1));
                if (kind < 25) begin
                    // broken sequence: one character replaced, turned into a pad or dropped
                    pos = $urandom_range(0, msg_buf.size() - 1);
                    case ($urandom_range(0, 2))
                        0: msg_buf[pos].character = 8'($urandom_range(0, 255));
                        1: msg_buf[pos].character = b64d_pkg::PAD_CHAR;
                        default: if (msg_buf.size() > 1) msg_buf.delete(pos);
                    endcase
                end
            end
            random_count = random_count + msg_buf.size();
            queue_message("");
        end
    end

    // reset once at the start
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sender: offers the pending characters with random idle bursts, and
    // predicts the output of every character at the edge that accepts it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted_outs.insert(predicted_outs.size(), decode_char(i_in_data));
                chars_sent <= chars_sent + 1;
            end
            // a new character may go out only once the current one is taken
            if (!i_in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_chars.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
                    // idle burst: this cycle plus send_gap more
                    send_gap   <= $urandom_range(0, 2);
                    i_in_valid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_chars.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once, so both registers fill and o_in_ready drops
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            backlog_hold <= 0;
            backlog_done <= 1'b0;
        end else if (backlog_hold != 0) begin
            backlog_hold <= backlog_hold - 1;
        end else if (!backlog_done && chars_sent >= BACKLOG_AT) begin
            backlog_hold <= BACKLOG_LEN;
            backlog_done <= 1'b1;
        end
    end

    // receiver: checks every accepted output against the oldest prediction,
    // and stalls in random bursts
    always @(posedge i_clk) begin : receiver
        b64d_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_outs.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected output: byte %h valid %b err %0d end %b",
                                 o_out_data.data_byte, o_out_data.byte_valid,
                                 o_out_data.error_code, o_out_data.message_end);
                    fail_count <= fail_count + 1;
                end else begin
                    want = predicted_outs.pop_front();
                    if (o_out_data.data_byte !== want.data_byte
                            || o_out_data.byte_valid !== want.byte_valid
                            || o_out_data.error_code !== want.error_code
                            || o_out_data.message_end !== want.message_end) begin
                        if (fail_count < 10)
                            $display({"mismatch: exp byte %h valid %b err %0d end %b,",
                                      " act byte %h valid %b err %0d end %b"},
                                     want.data_byte, want.byte_valid, want.error_code,
                                     want.message_end, o_out_data.data_byte,
                                     o_out_data.byte_valid, o_out_data.error_code,
                                     o_out_data.message_end);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left  <= stall_left - 1;
                i_out_ready <= 1'b0;
            end else if (pending_chars.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
                // stall burst: this cycle plus stall_left more
                stall_left  <= $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (backlog_hold == 0);
            end
        end
    end

    // end of run: everything sent and answered, then a quiet wait
    // to catch stray outputs
    initial begin
        @(posedge i_clk);
        while (!i_rst_n || pending_chars.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (predicted_outs.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && predicted_outs.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #3_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
